// ===== rtl/core/bfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned STORE_BYTES_DEF = 1024;
  localparam int unsigned HASH_COUNT_DEF  = 4;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_SEL_W = 3;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CFG_W-1:0] BITMAP_BYTES_RST = 11'd1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_BITMAP_BYTES = 1'b0;

  // Remainder unit: radix-16 restoring reduction, one digit per cycle
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIGITS      = WORD_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGITS);

endpackage

`default_nettype wire

// ===== rtl/core/bfm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/bfm_rem_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Remainder of a 32-bit dividend by a runtime divisor, four quotient bits
// per cycle. done pulses while rem first shows the final remainder; rem then holds.
module bfm_rem_unit #(
  parameter int unsigned RW = 11
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bfm_pkg::WORD_W-1:0] dividend,
  input  wire logic [RW-1:0]             divisor,
  output logic                           done,
  output logic [RW-1:0]                  rem
);

  logic                              active_r;
  logic                              done_r;
  logic [bfm_pkg::DIGIT_CNT_W-1:0]   cnt_r;
  logic [bfm_pkg::WORD_W-1:0]        q_r;
  logic [RW-1:0]                     r_r;
  logic [RW-1:0]                     r_nxt;
  logic [RW:0]                       acc;

  // r stays below divisor, so each shifted partial fits in RW+1 bits
  always_comb begin
    acc = {1'b0, r_r};
    for (int i = 0; i < int'(bfm_pkg::DIGIT_W); i++) begin
      acc = {acc[RW-1:0], q_r[bfm_pkg::WORD_W-1-i]};
      if (acc >= {1'b0, divisor}) begin
        acc = acc - {1'b0, divisor};
      end
    end
    r_nxt = acc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bfm_pkg::DIGIT_CNT_W'(bfm_pkg::DIGITS - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (active_r) begin
      q_r <= q_r << bfm_pkg::DIGIT_W;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

// ===== rtl/core/bloom_filter_membership_top.sv =====
// Bloom filter membership block. Pulse start while busy is low to transfer
// an operation (lookup, insert, clear) and its hash words; one result
// follows on out_valid/out_found for exactly one cycle, and the receiver
// cannot stall it. Each hash word passes through the shared radix-16
// remainder unit, then a store read and a check or read-modify-write;
// a lookup ends early at the first clear bit. Clear sweeps the byte store
// one byte per cycle, and the same sweep runs after reset, with busy high,
// before the first transfer. The unused op code answers found = 0 in the
// cycle after the transfer. The user must write bitmap_bytes over the APB
// port only while busy is low; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module bloom_filter_membership_top #(
  parameter int unsigned STORE_BYTES = bfm_pkg::STORE_BYTES_DEF,
  parameter int unsigned HASH_COUNT  = bfm_pkg::HASH_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [bfm_pkg::OP_W-1:0]     in_op,
  input  wire logic [bfm_pkg::WORD_W-1:0]   in_hash_word_0,
  input  wire logic [bfm_pkg::WORD_W-1:0]   in_hash_word_1,
  input  wire logic [bfm_pkg::WORD_W-1:0]   in_hash_word_2,
  input  wire logic [bfm_pkg::WORD_W-1:0]   in_hash_word_3,
  // result channel
  output logic                              out_valid,
  output logic                              out_found,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bfm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bfm_pkg::APB_DW-1:0]   pwdata,
  output logic      [bfm_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned RW = $clog2(STORE_BYTES + 1);
  localparam int unsigned KW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_REM,
    S_CHK
  } state_t;

  state_t                            state_r;
  logic [bfm_pkg::CFG_W-1:0]         bitmap_bytes_r;
  logic [bfm_pkg::OP_W-1:0]          op_r;
  logic [bfm_pkg::WORD_W-1:0]        hw_r [HASH_COUNT];
  logic [KW-1:0]                     k_r;
  logic [KW-1:0]                     k_inc;
  logic [AW-1:0]                     clr_addr_r;
  logic                              clr_op_r;
  logic                              out_valid_r;
  logic                              out_found_r;

  logic [bfm_pkg::WORD_W-1:0]        in_words [4];
  logic [bfm_pkg::WORD_W-1:0]        n_wide;
  logic [RW-1:0]                     n_bytes;
  logic                              accept;
  logic                              cfg_wr;

  logic                              rem_start;
  logic [bfm_pkg::WORD_W-1:0]        rem_word;
  logic [bfm_pkg::WORD_W-1:0]        rem_dividend;
  logic                              rem_done;
  logic [RW-1:0]                     rem_out;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [bfm_pkg::BYTE_W-1:0]        ram_wdata;
  logic [bfm_pkg::BYTE_W-1:0]        ram_rdata;
  logic [bfm_pkg::BIT_SEL_W-1:0]     bit_sel;
  logic                              last_word;

  assign in_words[0] = in_hash_word_0;
  assign in_words[1] = in_hash_word_1;
  assign in_words[2] = in_hash_word_2;
  assign in_words[3] = in_hash_word_3;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_bytes_r <= bfm_pkg::BITMAP_BYTES_RST;
    end else if (cfg_wr && paddr[2] == bfm_pkg::REG_BITMAP_BYTES) begin
      bitmap_bytes_r <= pwdata[bfm_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfm_pkg::REG_BITMAP_BYTES) begin
      prdata = {{(bfm_pkg::APB_DW - bfm_pkg::CFG_W){1'b0}}, bitmap_bytes_r};
    end
  end

  // Bytes in use, clamped to 1..STORE_BYTES
  always_comb begin
    n_wide = {{(bfm_pkg::WORD_W - bfm_pkg::CFG_W){1'b0}}, bitmap_bytes_r};
    if (n_wide == '0) begin
      n_wide = 32'd1;
    end else if (n_wide > bfm_pkg::WORD_W'(STORE_BYTES)) begin
      n_wide = bfm_pkg::WORD_W'(STORE_BYTES);
    end
    n_bytes = n_wide[RW-1:0];
  end

  // ---------------- remainder unit ----------------
  // word mod 8n = 8 * ((word >> 3) mod n) + word[2:0]
  assign k_inc     = k_r + 1'b1;
  assign last_word = (k_r == KW'(HASH_COUNT - 1));
  assign rem_word  = (state_r == S_IDLE) ? in_hash_word_0 : hw_r[k_inc];
  assign rem_dividend = {{bfm_pkg::BIT_SEL_W{1'b0}},
                         rem_word[bfm_pkg::WORD_W-1:bfm_pkg::BIT_SEL_W]};

  always_comb begin
    rem_start = 1'b0;
    if (accept && (in_op == bfm_pkg::OP_LOOKUP || in_op == bfm_pkg::OP_INSERT)) begin
      rem_start = 1'b1;
    end else if (state_r == S_CHK && !last_word) begin
      // a lookup that hits a clear bit ends here instead
      rem_start = !(op_r == bfm_pkg::OP_LOOKUP && !ram_rdata[bit_sel]);
    end
  end

  bfm_rem_unit #(
    .RW(RW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (n_bytes),
    .done     (rem_done),
    .rem      (rem_out)
  );

  // ---------------- bit store ----------------
  assign bit_sel = hw_r[k_r][bfm_pkg::BIT_SEL_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rem_out[AW-1:0];
    ram_wdata = ram_rdata | (bfm_pkg::BYTE_W'(1) << bit_sel);
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == S_CHK && op_r == bfm_pkg::OP_INSERT) begin
      ram_we = 1'b1;
    end
  end

  bfm_ram #(
    .WIDTH (bfm_pkg::BYTE_W),
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rem_out[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_op_r    <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(STORE_BYTES - 1)) begin
            state_r     <= S_IDLE;
            clr_addr_r  <= '0;
            clr_op_r    <= 1'b0;
            out_valid_r <= clr_op_r;
          end
        end
        S_IDLE: begin
          if (accept) begin
            k_r <= '0;
            priority case (in_op)
              bfm_pkg::OP_LOOKUP, bfm_pkg::OP_INSERT: begin
                state_r <= S_REM;
              end
              bfm_pkg::OP_CLEAR: begin
                state_r  <= S_CLR;
                clr_op_r <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_REM: begin
          // store read issues at this edge from the remainder
          if (rem_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (op_r == bfm_pkg::OP_LOOKUP && !ram_rdata[bit_sel]) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else if (last_word) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_found_r <= (op_r == bfm_pkg::OP_LOOKUP);
          end else begin
            k_r     <= k_inc;
            state_r <= S_REM;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      for (int i = 0; i < int'(HASH_COUNT); i++) begin
        hw_r[i] <= in_words[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // ---------------- assertions ----------------
  a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> state_r == S_REM)
    else $error("remainder finished outside its wait state");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> rem_out < n_bytes)
    else $error("remainder not below byte count");

  a_store_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_CHK))
    else $error("store written outside clear or update");

  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE || state_r == S_REM || state_r == S_CLR)
    else $error("result strobe while checking a bit");

endmodule

`default_nettype wire
